[src/htd_pkg.sv]
// Package for the prefix-code table decoder.
// Holds the field widths, request operation codes and default parameter values.
// It has no dependencies.
package htd_pkg;

   localparam int SYMBOL_W   = 8;
   localparam int INDEX_W    = 8;
   localparam int LENGTH_W   = 6;
   localparam int CODE_W     = 32;
   localparam int PAYLOAD_W  = 32;

   localparam int TABLE_DEPTH_DEF  = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_BIT  = 1'b1;

endpackage

[src/huffman_table_decoder_core.sv]
// Prefix-code table decoder: a table memory with valid bits, a code accumulator and a
// sequencer that scans the table one slot per cycle for each payload bit.
// Depends on htd_pkg.
//
// A load request and a padding bit are taken without leaving the idle state. A payload bit
// request starts a scan, which gives no result when no slot matches short of the maximum code
// length: the read port visits one slot per cycle and the scan stops at the first matching
// slot. A new result waits, holding the block, while an earlier one is stalled at the output.
// Reset clears the valid bits of all slots at once, so the block is ready in the cycle after
// reset.
module huffman_table_decoder_core #(
   parameter int TABLE_DEPTH  = htd_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [htd_pkg::PAYLOAD_W-1:0] csr_payload_bits,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [htd_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [htd_pkg::SYMBOL_W-1:0]  req_entry_symbol,
   input  logic [htd_pkg::LENGTH_W-1:0]  req_entry_length,
   input  logic [htd_pkg::CODE_W-1:0]    req_entry_code,
   input  logic                          req_code_bit,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [htd_pkg::SYMBOL_W-1:0]  rsp_symbol,
   output logic                          rsp_bad_code,
   output logic                          rsp_last_symbol
);
   import htd_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
   localparam int CMP_W  = INDEX_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_CODE_LEN);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [SYMBOL_W-1:0]     sym_mem  [TABLE_DEPTH];
   logic [LENGTH_W-1:0]     len_mem  [TABLE_DEPTH];
   logic [MAX_CODE_LEN-1:0] code_mem [TABLE_DEPTH];

   logic [1:0]              state_ff, state_in;
   logic [PAYLOAD_W-1:0]    payload_bits_ff, payload_bits_in;
   logic [PAYLOAD_W-1:0]    consumed_ff, consumed_in;
   logic [MAX_CODE_LEN-1:0] accum_ff, accum_in;
   logic [MAX_CODE_LEN-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    last_ff, last_in;
   logic [ADDR_W-1:0]       scan_addr_ff, scan_addr_in;
   logic                    cmp_live_ff, cmp_live_in;
   logic                    rd_last_ff;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic                    rd_valid_ff;
   logic [SYMBOL_W-1:0]     rd_sym_ff;
   logic [LENGTH_W-1:0]     rd_len_ff;
   logic [MAX_CODE_LEN-1:0] rd_code_ff;
   logic [SYMBOL_W-1:0]     res_symbol_ff, res_symbol_in;
   logic                    res_bad_ff, res_bad_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0]     rsp_symbol_ff;
   logic                    rsp_bad_ff;
   logic                    rsp_last_ff;

   logic                    req_accept;
   logic                    table_we;
   logic [ADDR_W-1:0]       table_waddr;
   logic                    rsp_free;
   logic                    slot_match;
   logic [PAYLOAD_W-1:0]    consumed_inc;

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_bad_code    = rsp_bad_ff;
   assign rsp_last_symbol = rsp_last_ff;

   assign req_accept   = req_valid && !req_stall;
   assign table_we     = req_accept && (req_op == OP_LOAD) &&
                         ({1'b0, req_entry_index} < CMP_W'(TABLE_DEPTH));
   assign table_waddr  = req_entry_index[ADDR_W-1:0];
   assign rsp_free     = !(rsp_valid_ff && rsp_stall);
   assign consumed_inc = consumed_ff + PAYLOAD_W'(1);
   assign slot_match   = cmp_live_ff && rd_valid_ff &&
                         (rd_len_ff == LENGTH_W'(count_ff)) &&
                         ((rd_code_ff & mask_ff) == accum_ff);

   always_comb begin
      state_in        = state_ff;
      payload_bits_in = payload_bits_ff;
      consumed_in     = consumed_ff;
      accum_in        = accum_ff;
      mask_in         = mask_ff;
      count_in        = count_ff;
      last_in         = last_ff;
      scan_addr_in    = scan_addr_ff;
      cmp_live_in     = cmp_live_ff;
      valid_in        = valid_ff;
      res_symbol_in   = res_symbol_ff;
      res_bad_in      = res_bad_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         payload_bits_in = csr_payload_bits;
      end
      if (table_we) begin
         valid_in[table_waddr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == OP_BIT) && (consumed_ff < payload_bits_ff)) begin
               consumed_in  = consumed_inc;
               accum_in     = {accum_ff[MAX_CODE_LEN-2:0], req_code_bit};
               mask_in      = {mask_ff[MAX_CODE_LEN-2:0], 1'b1};
               count_in     = count_ff + CNT_W'(1);
               last_in      = (consumed_inc == payload_bits_ff);
               scan_addr_in = '0;
               cmp_live_in  = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (slot_match) begin
               res_symbol_in = rd_sym_ff;
               res_bad_in    = 1'b0;
               accum_in      = '0;
               mask_in       = '0;
               count_in      = '0;
               state_in      = ST_FIN;
            end else if (cmp_live_ff && rd_last_ff) begin
               if (count_ff == MAX_CNT) begin
                  res_symbol_in = '0;
                  res_bad_in    = 1'b1;
                  accum_in      = '0;
                  mask_in       = '0;
                  count_in      = '0;
                  state_in      = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cmp_live_in = 1'b1;
               if (scan_addr_ff != LAST_ADDR) begin
                  scan_addr_in = scan_addr_ff + ADDR_W'(1);
               end
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         payload_bits_ff <= '0;
         consumed_ff     <= '0;
         accum_ff        <= '0;
         mask_ff         <= '0;
         count_ff        <= '0;
         last_ff         <= 1'b0;
         scan_addr_ff    <= '0;
         cmp_live_ff     <= 1'b0;
         rd_last_ff      <= 1'b0;
         valid_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         payload_bits_ff <= payload_bits_in;
         consumed_ff     <= consumed_in;
         accum_ff        <= accum_in;
         mask_ff         <= mask_in;
         count_ff        <= count_in;
         last_ff         <= last_in;
         scan_addr_ff    <= scan_addr_in;
         cmp_live_ff     <= cmp_live_in;
         rd_last_ff      <= (scan_addr_ff == LAST_ADDR);
         valid_ff        <= valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         sym_mem[table_waddr]  <= req_entry_symbol;
         len_mem[table_waddr]  <= req_entry_length;
         code_mem[table_waddr] <= req_entry_code[MAX_CODE_LEN-1:0];
      end
      rd_sym_ff   <= sym_mem[scan_addr_ff];
      rd_len_ff   <= len_mem[scan_addr_ff];
      rd_code_ff  <= code_mem[scan_addr_ff];
      rd_valid_ff <= valid_ff[scan_addr_ff];
   end

   always_ff @(posedge clock) begin
      res_symbol_ff <= res_symbol_in;
      res_bad_ff    <= res_bad_in;
      if ((state_ff == ST_FIN) && rsp_free) begin
         rsp_symbol_ff <= res_symbol_ff;
         rsp_bad_ff    <= res_bad_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   // A flagged code never carries a symbol.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_code) |-> (rsp_symbol == '0))
      else $error("bad code result carries a symbol");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("code count beyond the maximum length");

   // The compare mask always covers exactly the accumulated bits.
   assert property (@(posedge clock) disable iff (reset)
      $countones(mask_ff) == int'(count_ff))
      else $error("compare mask out of step with code count");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_BIT) && (consumed_ff < payload_bits_ff))
      |=> (state_ff == ST_SCAN) && (consumed_ff == $past(consumed_inc)))
      else $error("payload bit request did not start a scan");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (count_ff == '0))
      else $error("accumulator not cleared with a result");

endmodule
